// ===== hw/rtl/sensor_integer_compensation_core_macros.svh =====
// assertion macros for the sensor compensation core
// used by sensor_integer_compensation_core.sv, expects aclk and aresetn in scope
`ifndef SENSOR_INTEGER_COMPENSATION_CORE_MACROS_SVH
`define SENSOR_INTEGER_COMPENSATION_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SIC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sic assertion failed");
// next-cycle implication
`define SIC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sic assertion failed");
`else
`define SIC_ASSERT_IMP(lbl, ante, cons)
`define SIC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/sic_pkg.sv =====
// shared types, constants, shift and sign-extension helpers of the sensor compensation core
// no dependencies
package sic_pkg;

    // pipeline shape
    localparam int DIV_W    = 64;
    localparam int FRONT_ST = 12;
    localparam int BACK_ST  = 7;
    localparam int NST      = FRONT_ST + DIV_W + BACK_ST;

    // register indexes
    typedef enum logic [2:0] {
        REG_TEMP_CALIB  = 3'd0,
        REG_PRESS_LOW   = 3'd1,
        REG_PRESS_HIGH  = 3'd2,
        REG_PRESS_LAST  = 3'd3,
        REG_HUM_A       = 3'd4,
        REG_HUM_B       = 3'd5
    } cfg_reg_t;

    localparam logic [31:0] HUM_MAX    = 32'd419430400;
    localparam logic [63:0] PRESS_BIAS = 64'h0000_8000_0000_0000;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx49(input logic [48:0] v);
        return {{15{v[48]}}, v};
    endfunction

endpackage

// ===== hw/rtl/sensor_integer_compensation_core.sv =====
// top level of the sensor compensation core: pipelined temperature, pressure
// and humidity compensation with a pipelined 64-bit divider
// depends on sic_pkg and sensor_integer_compensation_core_macros.svh
//
// usage
//   s_ channel carries one raw sample per item, m_ channel one compensated
//   result per item, in the same order
//   calibration words are written through cfg_wr_en / cfg_index / cfg_wdata
//   while the core is idle; indexes above five are ignored
//   throughput: one item per cycle unless a held result stalls the pipeline
//   depth: 83 register stages from acceptance to m_tvalid; 64 of them are
//   the restoring divider, one quotient bit per stage
//   all stages advance together whenever the output register is empty or
//   being taken, so s_tready follows !m_tvalid || m_tready
//   when the receiver stalls the whole pipeline holds, nothing is lost
//   reset clears valid bits and calibration registers, payload is not reset
//   a zero pressure divisor gives pressure 0 and sets m_tuser
`include "sensor_integer_compensation_core_macros.svh"

module sensor_integer_compensation_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // temp_centi[31:0], press_q24_8[63:32], hum_q22_10[80:64]
    output logic [0:0]  m_tuser    // press_invalid[0]
);
    import sic_pkg::*;

    // calibration registers
    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_last_reg;
    logic [31:0] hum_a_reg;
    logic [39:0] hum_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_last_reg <= '0;
            hum_a_reg      <= '0;
            hum_b_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TEMP_CALIB: temp_calib_reg <= cfg_wdata[47:0];
                REG_PRESS_LOW:  press_low_reg  <= cfg_wdata;
                REG_PRESS_HIGH: press_high_reg <= cfg_wdata;
                REG_PRESS_LAST: press_last_reg <= cfg_wdata[15:0];
                REG_HUM_A:      hum_a_reg      <= cfg_wdata[31:0];
                REG_HUM_B:      hum_b_reg      <= cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    // coefficient slices
    logic        [15:0] t1;
    logic signed [15:0] t2_s, t3_s;
    logic        [15:0] p1;
    logic signed [15:0] p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;
    logic        [7:0]  h1, h3;
    logic signed [15:0] h2_s, h4_s, h5_s;
    logic signed [7:0]  h6_s;

    assign t1   = temp_calib_reg[15:0];
    assign t2_s = temp_calib_reg[31:16];
    assign t3_s = temp_calib_reg[47:32];
    assign p1   = press_low_reg[15:0];
    assign p2_s = press_low_reg[31:16];
    assign p3_s = press_low_reg[47:32];
    assign p4_s = press_low_reg[63:48];
    assign p5_s = press_high_reg[15:0];
    assign p6_s = press_high_reg[31:16];
    assign p7_s = press_high_reg[47:32];
    assign p8_s = press_high_reg[63:48];
    assign p9_s = press_last_reg;
    assign h1   = hum_a_reg[7:0];
    assign h2_s = hum_a_reg[23:8];
    assign h3   = hum_a_reg[31:24];
    assign h4_s = hum_b_reg[15:0];
    assign h5_s = hum_b_reg[31:16];
    assign h6_s = hum_b_reg[39:32];

    // pipeline advance: every stage moves when the output can
    logic adv;
    logic [NST-1:0] vld_reg;

    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------
    // front stages: temperature, pressure divisor/dividend, humidity
    // ---------------------------------------------------------------
    logic [19:0] f0_rt_reg;
    logic [19:0] rp_line_reg [0:8];
    logic [15:0] rh_line_reg [0:4];
    logic [31:0] temp_line_reg [0:7];

    logic [31:0] f1_ta_reg, f1_dd_reg;
    logic [31:0] f2_a_reg, f2_tb_reg;
    logic [31:0] f3_tf_reg;
    logic [32:0] f4_v1_reg;
    logic [31:0] f4_x_reg;
    logic [63:0] f5_sq_reg;
    logic [48:0] f5_v1p5_reg, f5_v1p2_reg;
    logic [31:0] f5_lhs_reg, f5_q6m_reg, f5_q3m_reg;
    logic [63:0] f6_v2a_reg, f6_v1a_reg;
    logic [48:0] f6_v1p5_reg, f6_v1p2_reg;
    logic [31:0] f6_qq_reg, f6_lhs_reg;
    logic [63:0] f7_v2_reg, f7_v1b_reg;
    logic [31:0] f7_rm_reg, f7_lhs_reg;
    logic [63:0] f8_v1c_reg, f8_v2_reg;
    logic [31:0] f8_h_reg;
    logic [63:0] f9_dvs_reg, f9_num0_reg;
    logic [31:0] f9_hh_reg, f9_h_reg;
    logic [63:0] f10_num_reg, f10_dvs_reg;
    logic [31:0] f10_hm_reg, f10_h_reg;
    logic [63:0] f11_ma_reg, f11_mb_reg;
    logic        f11_neg_reg, f11_bad_reg;
    logic [16:0] f11_hum_reg;

    // temperature products
    logic        [31:0] ta_l;
    logic signed [47:0] ta_p;
    logic signed [16:0] d_s;
    logic signed [33:0] dd_p;
    logic signed [47:0] tb_p;

    assign ta_l = {15'd0, f0_rt_reg[19:3]} - {15'd0, t1, 1'b0};
    assign ta_p = $signed(ta_l) * t2_s;
    assign d_s  = $signed({1'b0, f0_rt_reg[19:4]}) - $signed({1'b0, t1});
    assign dd_p = d_s * d_s;
    assign tb_p = $signed(asr32(f1_dd_reg, 12)) * t3_s;

    // pressure products
    logic signed [65:0] sq_p;
    logic signed [48:0] v1p5_p, v1p2_p;
    logic signed [79:0] v2a_p, v1a_p;
    logic signed [80:0] v1c_p;
    logic        [63:0] v1_biased;
    logic        [20:0] pn;

    assign sq_p      = $signed(f4_v1_reg) * $signed(f4_v1_reg);
    assign v1p5_p    = $signed(f4_v1_reg) * p5_s;
    assign v1p2_p    = $signed(f4_v1_reg) * p2_s;
    assign v2a_p     = $signed(f5_sq_reg) * p6_s;
    assign v1a_p     = $signed(f5_sq_reg) * p3_s;
    assign v1_biased = f7_v1b_reg + PRESS_BIAS;
    assign v1c_p     = $signed(v1_biased) * $signed({1'b0, p1});
    assign pn        = 21'd1048576 - {1'b0, rp_line_reg[8]};

    // humidity products
    logic signed [47:0] h5x_p;
    logic signed [39:0] x6_p;
    logic signed [40:0] x3_p;
    logic        [31:0] q3_v, rhs0_v, rhs_v, hs_v, hr_v;
    logic signed [63:0] qq_p, hp_p, hh_p;
    logic signed [47:0] rm_p;
    logic signed [40:0] hm_p;

    assign h5x_p  = $signed(f4_x_reg) * h5_s;
    assign x6_p   = $signed(f4_x_reg) * h6_s;
    assign x3_p   = $signed(f4_x_reg) * $signed({1'b0, h3});
    assign q3_v   = asr32(f5_q3m_reg, 11) + 32'd32768;
    assign qq_p   = $signed(asr32(f5_q6m_reg, 10)) * $signed(q3_v);
    assign rhs0_v = asr32(f6_qq_reg, 10) + 32'd2097152;
    assign rm_p   = $signed(rhs0_v) * h2_s;
    assign rhs_v  = asr32(f7_rm_reg + 32'd8192, 14);
    assign hp_p   = $signed(f7_lhs_reg) * $signed(rhs_v);
    assign hs_v   = asr32(f8_h_reg, 15);
    assign hh_p   = $signed(hs_v) * $signed(hs_v);
    assign hm_p   = $signed(asr32(f9_hh_reg, 7)) * $signed({1'b0, h1});
    assign hr_v   = f10_h_reg - asr32(f10_hm_reg, 4);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 0: capture the sample
            f0_rt_reg      <= s_tdata[19:0];
            rp_line_reg[0] <= s_tdata[39:20];
            rh_line_reg[0] <= s_tdata[55:40];
            for (int i = 1; i < 9; i++) begin
                rp_line_reg[i] <= rp_line_reg[i-1];
            end
            for (int i = 1; i < 5; i++) begin
                rh_line_reg[i] <= rh_line_reg[i-1];
            end
            // stages 1 to 3: fine temperature
            f1_ta_reg <= ta_p[31:0];
            f1_dd_reg <= dd_p[31:0];
            f2_a_reg  <= asr32(f1_ta_reg, 11);
            f2_tb_reg <= tb_p[31:0];
            f3_tf_reg <= f2_a_reg + asr32(f2_tb_reg, 14);
            // stage 4: temperature result and offsets for the other formulas
            temp_line_reg[0] <= asr32({f3_tf_reg[29:0], 2'b00} + f3_tf_reg + 32'd128, 8);
            for (int i = 1; i < 8; i++) begin
                temp_line_reg[i] <= temp_line_reg[i-1];
            end
            f4_v1_reg <= {f3_tf_reg[31], f3_tf_reg} - 33'd128000;
            f4_x_reg  <= f3_tf_reg - 32'd76800;
            // stage 5
            f5_sq_reg   <= sq_p[63:0];
            f5_v1p5_reg <= v1p5_p;
            f5_v1p2_reg <= v1p2_p;
            f5_lhs_reg  <= {2'b00, rh_line_reg[4], 14'd0} - {h4_s[11:0], 20'd0}
                           - h5x_p[31:0] + 32'd16384;
            f5_q6m_reg  <= x6_p[31:0];
            f5_q3m_reg  <= x3_p[31:0];
            // stage 6
            f6_v2a_reg  <= v2a_p[63:0];
            f6_v1a_reg  <= v1a_p[63:0];
            f6_v1p5_reg <= f5_v1p5_reg;
            f6_v1p2_reg <= f5_v1p2_reg;
            f6_qq_reg   <= qq_p[31:0];
            f6_lhs_reg  <= asr32(f5_lhs_reg, 15);
            // stage 7
            f7_v2_reg  <= f6_v2a_reg + (sx49(f6_v1p5_reg) << 17) + (sx16(p4_s) << 35);
            f7_v1b_reg <= asr64(f6_v1a_reg, 8) + (sx49(f6_v1p2_reg) << 12);
            f7_rm_reg  <= rm_p[31:0];
            f7_lhs_reg <= f6_lhs_reg;
            // stage 8
            f8_v1c_reg <= v1c_p[63:0];
            f8_v2_reg  <= f7_v2_reg;
            f8_h_reg   <= hp_p[31:0];
            // stage 9: divisor and raw dividend
            f9_dvs_reg  <= asr64(f8_v1c_reg, 33);
            f9_num0_reg <= ({43'd0, pn} << 31) - f8_v2_reg;
            f9_hh_reg   <= hh_p[31:0];
            f9_h_reg    <= f8_h_reg;
            // stage 10
            f10_num_reg <= f9_num0_reg * 64'd3125;
            f10_dvs_reg <= f9_dvs_reg;
            f10_hm_reg  <= hm_p[31:0];
            f10_h_reg   <= f9_h_reg;
            // stage 11: magnitudes for the divider, humidity clamp
            f11_ma_reg  <= f10_num_reg[63] ? (64'd0 - f10_num_reg) : f10_num_reg;
            f11_mb_reg  <= f10_dvs_reg[63] ? (64'd0 - f10_dvs_reg) : f10_dvs_reg;
            f11_neg_reg <= f10_num_reg[63] ^ f10_dvs_reg[63];
            f11_bad_reg <= (f10_dvs_reg == 64'd0);
            if (hr_v[31]) begin
                f11_hum_reg <= 17'd0;
            end else if (hr_v > HUM_MAX) begin
                f11_hum_reg <= HUM_MAX[28:12];
            end else begin
                f11_hum_reg <= hr_v[28:12];
            end
        end
    end

    // ---------------------------------------------------------------
    // restoring divider, one quotient bit per stage
    // ---------------------------------------------------------------
    logic [63:0] drem_reg [0:DIV_W-2];
    logic [63:0] dmb_reg  [0:DIV_W-2];
    logic [63:0] dq_reg   [0:DIV_W-1];
    logic        dneg_reg [0:DIV_W-1];
    logic        dbad_reg [0:DIV_W-1];
    logic [31:0] dtemp_reg [0:DIV_W-1];
    logic [16:0] dhum_reg [0:DIV_W-1];

    for (genvar k = 0; k < DIV_W; k++) begin : g_div
        logic [63:0] rem_in, dq_in, mb_in, sh;
        logic        ge, neg_in, bad_in;
        logic [31:0] temp_in;
        logic [16:0] hum_in;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign dq_in   = f11_ma_reg;
            assign mb_in   = f11_mb_reg;
            assign neg_in  = f11_neg_reg;
            assign bad_in  = f11_bad_reg;
            assign temp_in = temp_line_reg[7];
            assign hum_in  = f11_hum_reg;
        end else begin : g_next
            assign rem_in  = drem_reg[k-1];
            assign dq_in   = dq_reg[k-1];
            assign mb_in   = dmb_reg[k-1];
            assign neg_in  = dneg_reg[k-1];
            assign bad_in  = dbad_reg[k-1];
            assign temp_in = dtemp_reg[k-1];
            assign hum_in  = dhum_reg[k-1];
        end

        // partial remainder stays below the divisor, so its top bit is free
        assign sh = {rem_in[62:0], dq_in[63]};
        assign ge = (sh >= mb_in);

        always_ff @(posedge aclk) begin
            if (adv) begin
                dq_reg[k]    <= {dq_in[62:0], ge};
                dneg_reg[k]  <= neg_in;
                dbad_reg[k]  <= bad_in;
                dtemp_reg[k] <= temp_in;
                dhum_reg[k]  <= hum_in;
            end
        end

        if (k < DIV_W - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (adv) begin
                    drem_reg[k] <= ge ? (sh - mb_in) : sh;
                    dmb_reg[k]  <= mb_in;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // back stages: pressure correction terms
    // ---------------------------------------------------------------
    logic [31:0] bk_temp_reg [0:BACK_ST-1];
    logic [16:0] bk_hum_reg  [0:BACK_ST-1];
    logic        bk_bad_reg  [0:BACK_ST-1];

    logic [63:0] b1_p_reg;
    logic [63:0] b2_p_reg, b2_ps_reg, b2_v2p_reg;
    logic [63:0] b3_p_reg, b3_ps_reg, b3_v2p_reg, b3_pp_reg;
    logic [63:0] b4_p_reg, b4_v2p_reg, b4_m0_reg;
    logic [31:0] b4_m1_reg, b4_m2_reg;
    logic [63:0] b5_p_reg, b5_v2p_reg, b5_pp2_reg;
    logic [63:0] b6_s_reg;
    logic [31:0] b7_press_reg;

    logic signed [79:0] v2p_p, pp_p;
    logic        [63:0] m0_w;
    logic        [31:0] m1_w, m2_w, pshift_w;
    logic        [63:0] pshift64_w;

    assign v2p_p      = $signed(b1_p_reg) * p8_s;
    assign pp_p       = $signed(b2_ps_reg) * p9_s;
    // low 64 bits of a 64 by 64 product from 32-bit partial products
    assign m0_w       = {32'd0, b3_pp_reg[31:0]} * {32'd0, b3_ps_reg[31:0]};
    assign m1_w       = b3_pp_reg[31:0] * b3_ps_reg[63:32];
    assign m2_w       = b3_pp_reg[63:32] * b3_ps_reg[31:0];
    assign pshift64_w = asr64(b6_s_reg, 8);
    assign pshift_w   = pshift64_w[31:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            bk_temp_reg[0] <= dtemp_reg[DIV_W-1];
            bk_hum_reg[0]  <= dhum_reg[DIV_W-1];
            bk_bad_reg[0]  <= dbad_reg[DIV_W-1];
            for (int i = 1; i < BACK_ST; i++) begin
                bk_temp_reg[i] <= bk_temp_reg[i-1];
                bk_hum_reg[i]  <= bk_hum_reg[i-1];
                bk_bad_reg[i]  <= bk_bad_reg[i-1];
            end
            // signed quotient, truncated toward zero
            b1_p_reg   <= dneg_reg[DIV_W-1] ? (64'd0 - dq_reg[DIV_W-1]) : dq_reg[DIV_W-1];
            b2_p_reg   <= b1_p_reg;
            b2_ps_reg  <= asr64(b1_p_reg, 13);
            b2_v2p_reg <= v2p_p[63:0];
            b3_p_reg   <= b2_p_reg;
            b3_ps_reg  <= b2_ps_reg;
            b3_v2p_reg <= b2_v2p_reg;
            b3_pp_reg  <= pp_p[63:0];
            b4_p_reg   <= b3_p_reg;
            b4_v2p_reg <= b3_v2p_reg;
            b4_m0_reg  <= m0_w;
            b4_m1_reg  <= m1_w;
            b4_m2_reg  <= m2_w;
            b5_p_reg   <= b4_p_reg;
            b5_v2p_reg <= b4_v2p_reg;
            b5_pp2_reg <= b4_m0_reg + {b4_m1_reg + b4_m2_reg, 32'd0};
            b6_s_reg   <= b5_p_reg + asr64(b5_pp2_reg, 25) + asr64(b5_v2p_reg, 19);
            // zero divisor forces pressure to zero
            if (bk_bad_reg[5]) begin
                b7_press_reg <= 32'd0;
            end else begin
                b7_press_reg <= pshift_w + {{12{p7_s[15]}}, p7_s, 4'd0};
            end
        end
    end

    assign m_tdata = {7'd0, bk_hum_reg[BACK_ST-1], b7_press_reg, bk_temp_reg[BACK_ST-1]};
    assign m_tuser = bk_bad_reg[BACK_ST-1];

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // an item in the last internal stage reaches the output when the pipe moves
    `SIC_ASSERT_NXT(a_last_stage_moves, vld_reg[NST-2] && adv, m_tvalid)
    // invalid pressure is always reported as zero
    `SIC_ASSERT_IMP(a_bad_press_zero, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0)
    // humidity never exceeds the upper clamp
    `SIC_ASSERT_IMP(a_hum_clamped, m_tvalid, m_tdata[80:64] <= 17'd102400)
    // no item is taken while a held result blocks the pipe
    `SIC_ASSERT_IMP(a_no_take_on_stall, m_tvalid && !m_tready, !s_tready)

endmodule

// ===== tb/tb_sensor_integer_compensation_core.sv =====
// self-checking testbench of sensor_integer_compensation_core
// drives raw samples and calibration words, predicts each result in sv and
// compares field by field; depends on sic_pkg and the core rtl
`timescale 1ns / 100ps

module tb_sensor_integer_compensation_core;
    import sic_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY        = 83;

    typedef struct packed {
        logic [15:0] raw_hum;
        logic [19:0] raw_press;
        logic [19:0] raw_temp;
    } sample_t;

    typedef struct {
        logic [31:0] temp_centi;
        logic [31:0] press_q24_8;
        logic [16:0] hum_q22_10;
        logic        press_invalid;
    } comp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [0:0]  m_tuser;

    // shadow copy of the calibration registers
    logic [47:0] cal_t;
    logic [63:0] cal_pl, cal_ph;
    logic [15:0] cal_p9;
    logic [31:0] cal_ha;
    logic [39:0] cal_hb;

    sample_t pending_samples[$];
    comp_t   expected_results[$];
    int      fail_count = 0;
    int      idle_cycles = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    bit      no_gaps = 0;

    sensor_integer_compensation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic comp_t compensate(sample_t smp);
        comp_t r;
        logic signed [31:0] t1, t2, t3, a, d, b, tf;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, num;
        logic [63:0] ma, mb, q;
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, lhs, q6, q3, rhs, h, hs;
        t1 = {16'd0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a  = (($signed({15'd0, smp.raw_temp[19:3]}) - (t1 <<< 1)) * t2) >>> 11;
        d  = $signed({16'd0, smp.raw_temp[19:4]}) - t1;
        b  = (((d * d) >>> 12) * t3) >>> 14;
        tf = a + b;
        r.temp_centi = (tf * 5 + 128) >>> 8;

        p1 = {48'd0, cal_pl[15:0]};
        p2 = {{48{cal_pl[31]}}, cal_pl[31:16]};
        p3 = {{48{cal_pl[47]}}, cal_pl[47:32]};
        p4 = {{48{cal_pl[63]}}, cal_pl[63:48]};
        p5 = {{48{cal_ph[15]}}, cal_ph[15:0]};
        p6 = {{48{cal_ph[31]}}, cal_ph[31:16]};
        p7 = {{48{cal_ph[47]}}, cal_ph[47:32]};
        p8 = {{48{cal_ph[63]}}, cal_ph[63:48]};
        p9 = {{48{cal_p9[15]}}, cal_p9};
        v1 = 64'(tf) - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        r.press_invalid = (v1 == 0);
        r.press_q24_8 = '0;
        if (v1 != 0) begin
            p   = 64'sd1048576 - $signed({44'd0, smp.raw_press});
            num = ((p <<< 31) - v2) * 64'sd3125;
            // truncating division, most negative over minus one wraps
            ma = num[63] ? -num : num;
            mb = v1[63] ? -v1 : v1;
            q  = ma / mb;
            p  = (num[63] != v1[63]) ? -q : q;
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.press_q24_8 = p[31:0];
        end

        h1 = {24'd0, cal_ha[7:0]};
        h2 = {{16{cal_ha[23]}}, cal_ha[23:8]};
        h3 = {24'd0, cal_ha[31:24]};
        h4 = {{16{cal_hb[15]}}, cal_hb[15:0]};
        h5 = {{16{cal_hb[31]}}, cal_hb[31:16]};
        h6 = {{24{cal_hb[39]}}, cal_hb[39:32]};
        x   = tf - 32'sd76800;
        lhs = (($signed({16'd0, smp.raw_hum}) <<< 14) - (h4 <<< 20) - (h5 * x) + 16384) >>> 15;
        q6  = (x * h6) >>> 10;
        q3  = ((x * h3) >>> 11) + 32768;
        rhs = ((q6 * q3) >>> 10) + 32'sd2097152;
        rhs = (rhs * h2 + 8192) >>> 14;
        h   = lhs * rhs;
        hs  = h >>> 15;
        h   = h - ((((hs * hs) >>> 7) * h1) >>> 4);
        // clamp at both ends
        if (h < 0)
            h = 0;
        else if (h > $signed(HUM_MAX))
            h = HUM_MAX;
        r.hum_q22_10 = h[28:12];
        return r;
    endfunction

    function automatic int pick_gap();
        if (no_gaps) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7: return $urandom_range(1, 3);
            8: return $urandom_range(4, 10);
            default: return $urandom_range(20, 120);
        endcase
    endfunction

    // driver: one item from the queue, random gaps between items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(compensate(sample_t'(s_tdata)));
                void'(pending_samples.pop_front());
                gap_left = pick_gap();
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare accepted results, random receiver stalls
    always @(posedge aclk) begin
        comp_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[31:0] !== e.temp_centi) begin
                        $error("temp_centi exp %0h got %0h", e.temp_centi, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[63:32] !== e.press_q24_8) begin
                        $error("press_q24_8 exp %0h got %0h", e.press_q24_8, m_tdata[63:32]);
                        fail_count++;
                    end
                    if (m_tdata[80:64] !== e.hum_q22_10) begin
                        $error("hum_q22_10 exp %0h got %0h", e.hum_q22_10, m_tdata[80:64]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== e.press_invalid) begin
                        $error("press_invalid exp %0b got %0b", e.press_invalid, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge aclk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sensor_integer_compensation_core NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_TEMP_CALIB: cal_t  = val[47:0];
            REG_PRESS_LOW:  cal_pl = val;
            REG_PRESS_HIGH: cal_ph = val;
            REG_PRESS_LAST: cal_p9 = val[15:0];
            REG_HUM_A:      cal_ha = val[31:0];
            default:        cal_hb = val[39:0];
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for the pipeline to drain before touching registers
    task automatic drain();
        while (pending_samples.size() > 0 || expected_results.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic set_all(input logic [63:0] t, pl, ph, p9, ha, hb);
        write_reg(REG_TEMP_CALIB, t);
        write_reg(REG_PRESS_LOW, pl);
        write_reg(REG_PRESS_HIGH, ph);
        write_reg(REG_PRESS_LAST, p9);
        write_reg(REG_HUM_A, ha);
        write_reg(REG_HUM_B, hb);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        s.raw_temp  = $urandom();
        s.raw_press = $urandom();
        s.raw_hum   = $urandom();
        return s;
    endfunction

    initial begin
        sample_t s;
        cal_t = '0; cal_pl = '0; cal_ph = '0; cal_p9 = '0; cal_ha = '0; cal_hb = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero calibration: pressure divisor zero, flag must rise
        pending_samples.push_back('0);
        pending_samples.push_back('1);
        drain();

        // typical device calibration, directed field extremes
        set_all({16'hFC18, 16'h6A52, 16'd27504}, {-16'sd7, 16'sd3024, -16'sd10685, 16'd36477},
                {16'sd4285, -16'sd10230, -16'sd7, 16'sd140}, 64'd6000,
                {8'd0, 16'sd359, 8'd75}, {8'sd30, 16'sd50, 16'sd339});
        no_gaps = 1;
        for (int i = 0; i < 8; i++) begin
            s.raw_temp  = (i & 1) ? 20'hFFFFF : 20'h0;
            s.raw_press = (i & 2) ? 20'hFFFFF : 20'h0;
            s.raw_hum   = (i & 4) ? 16'hFFFF : 16'h0;
            pending_samples.push_back(s);
        end
        pending_samples.push_back({16'd30000, 20'd415148, 20'd519888});
        pending_samples.push_back({16'd0, 20'hFFFFF, 20'd1});
        drain();
        no_gaps = 0;

        // extreme calibration words
        set_all('1, '1, '1, '1, '1, '1);
        for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample());
        drain();
        set_all(64'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
                64'h8000, 32'hFF80_00FF, 40'h80_8000_8000);
        for (int i = 0; i < 8; i++) pending_samples.push_back(rand_sample());
        drain();

        // random phases with random calibration, every third one a partly randomised typical set
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 0)
                set_all({16'hFC18, 16'h6A52, 16'd27504},
                        {16'hFFF9, 16'h0BD0, 16'hD643, 16'd36477},
                        {16'($urandom_range(0, 65535)), 16'hD80A, 16'hFFF9, 16'h10BD},
                        $urandom(), {8'd0, 16'd359, 8'd75}, {$urandom()} & 40'hFF_FFFF_FFFF);
            else
                set_all({$urandom(), $urandom()}, {$urandom(), $urandom()},
                        {$urandom(), $urandom()}, $urandom(), $urandom(),
                        {$urandom(), $urandom()});
            for (int i = 0; i < 110; i++) pending_samples.push_back(rand_sample());
            drain();
        end

        if (fail_count == 0)
            $display("tb_sensor_integer_compensation_core OK");
        else
            $display("tb_sensor_integer_compensation_core NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/sic_pkg.sv
hw/rtl/sensor_integer_compensation_core.sv
tb/tb_sensor_integer_compensation_core.sv
